>>> rtl/sorted_array_key_counter_macros.svh
// Assertion macros used by the sorted array key counter search sequencer.
`ifndef SORTED_ARRAY_KEY_COUNTER_MACROS_SVH
`define SORTED_ARRAY_KEY_COUNTER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define SAKC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define SAKC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/sakc_pkg.sv
// Package: sizes, codes, types and helpers for the sorted array key counter.
package sakc_pkg;

	localparam int DEPTH         = 1024;
	localparam int ELEMENT_WIDTH = 32;
	localparam int VALUE_W       = 32;
	localparam int OP_W          = 2;
	localparam int ADDR_W        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LEN_W         = $clog2(DEPTH + 1);

	localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

	typedef logic signed [ELEMENT_WIDTH-1:0] elem_t;
	typedef logic [LEN_W-1:0]                len_t;
	typedef logic [ADDR_W-1:0]               addr_t;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_COUNT  = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [0:0] {
		C_IDLE,
		C_BUSY
	} ctl_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ADDR,
		S_CMP
	} srch_state_t;

	// Search request from the controller.
	typedef struct packed {
		logic  go;
		elem_t key;
	} sakc_cmd_t;

	// Search result back to the controller.
	typedef struct packed {
		logic valid;
		len_t count;
	} sakc_res_t;

	// Sign-extend the input word, then keep ELEMENT_WIDTH bits.
	function automatic elem_t to_elem(input logic signed [VALUE_W-1:0] v);
		logic signed [63:0] wide;
		wide = 64'(v);
		return elem_t'(wide[ELEMENT_WIDTH-1:0]);
	endfunction

endpackage

>>> rtl/sakc_ram.sv
// Element store: one write port, one read port with registered read data.
module sakc_ram
	import sakc_pkg::*;
(
	input  logic  clk,
	input  logic  wr_en,
	input  addr_t wr_addr,
	input  elem_t wr_data,
	input  logic  rd_en,
	input  addr_t rd_addr,
	output elem_t rd_data
);

	elem_t mem [DEPTH];
	elem_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> rtl/sakc_search.sv
// Search sequencer: lower and upper bound passes over the store, one shared compare.
`include "sorted_array_key_counter_macros.svh"
module sakc_search
	import sakc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  sakc_cmd_t cmd,
	input  len_t      len,
	output logic      rd_en,
	output addr_t     rd_addr,
	input  elem_t     rd_data,
	output sakc_res_t res
);

	srch_state_t state_q, state_d;
	elem_t       key_q;
	len_t        len_q;
	len_t        lo_q, lo_d;
	len_t        hi_q, hi_d;
	len_t        mid_q;
	len_t        first_q;
	logic        upper_q, upper_d;
	logic        res_valid_q, res_valid_d;
	len_t        count_q;
	len_t        mid;
	logic        go_right;
	logic        load;
	logic        end_lower;

	assign mid      = lo_q + ((hi_q - lo_q) >> 1);
	// Shared compare: strict for the lower pass.
	assign go_right = upper_q ? (rd_data <= key_q) : (rd_data < key_q);

	always_comb begin
		state_d     = state_q;
		lo_d        = lo_q;
		hi_d        = hi_q;
		upper_d     = upper_q;
		res_valid_d = 1'b0;
		rd_en       = 1'b0;
		rd_addr     = mid[ADDR_W-1:0];
		load        = 1'b0;
		end_lower   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (cmd.go) begin
					load    = 1'b1;
					lo_d    = '0;
					hi_d    = len;
					upper_d = 1'b0;
					state_d = S_ADDR;
				end
			end
			S_ADDR: begin
				if (lo_q < hi_q) begin
					rd_en   = 1'b1;
					state_d = S_CMP;
				end else if (!upper_q) begin
					end_lower = 1'b1;
					lo_d      = '0;
					hi_d      = len_q;
					upper_d   = 1'b1;
				end else begin
					res_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			S_CMP: begin
				if (go_right) begin
					lo_d = mid_q + LEN_W'(1);
				end else begin
					hi_d = mid_q;
				end
				state_d = S_ADDR;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			upper_q     <= 1'b0;
		end else begin
			state_q     <= state_d;
			res_valid_q <= res_valid_d;
			upper_q     <= upper_d;
		end
	end

	always_ff @(posedge clk) begin
		lo_q <= lo_d;
		hi_q <= hi_d;
		if (load) begin
			key_q <= cmd.key;
			len_q <= len;
		end
		if (rd_en) begin
			mid_q <= mid;
		end
		if (end_lower) begin
			first_q <= lo_q;
		end
		if (res_valid_d) begin
			count_q <= (lo_q > first_q) ? (lo_q - first_q) : '0;
		end
	end

	assign res.valid = res_valid_q;
	assign res.count = count_q;

	`SAKC_ASSERT_NOW(a_rd_in_range, rd_en, mid < len_q, "read beyond filled part")
	`SAKC_ASSERT_NOW(a_count_bound, res.valid, res.count <= len_q, "count exceeds length")
	`SAKC_ASSERT_NEXT(a_strobe_once, res.valid, !res.valid, "result strobe longer than one cycle")
	`SAKC_ASSERT_NOW(a_window_open, state_q == S_CMP, lo_q < hi_q, "compare with empty window")

endmodule

>>> rtl/sorted_array_key_counter.sv
// Top level of the sorted array key counter: command decode, length, overflow.
//
//  channel   direction  transfer when       ports
//  command   in         start & !busy       operation, value
//  result    out        done (one cycle)    match_count, overflow
//
// Append and clear never raise busy, and the next command can follow at
// once. A count query holds busy high through a lower and an upper bound
// search, each of at most floor(log2(length))+1 probes: every probe issues a
// read on the single store read port and then compares the read data with
// the key. Reset clears length, overflow and the sequencer's state, result
// strobe and pass flag; its other registers and the store itself are not
// cleared. The receiver cannot stall: done is high for exactly one cycle
// with the result.
module sorted_array_key_counter
	import sakc_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [OP_W-1:0]            operation,
	input  logic signed [VALUE_W-1:0]  value,
	output logic                       done,
	output logic [LEN_W-1:0]           match_count,
	output logic                       overflow
);

	ctl_state_t state_q, state_d;
	len_t       length_q;
	logic       overflow_q;
	logic       accept;
	op_t        op;
	elem_t      elem;
	logic       wr_en;
	logic       srch_rd_en;
	addr_t      srch_rd_addr;
	elem_t      rd_data;
	sakc_cmd_t  cmd;
	sakc_res_t  res;

	// Take a command only while no query is in flight.
	assign accept = start && !busy;
	assign op     = op_t'(operation);
	assign elem   = to_elem(value);

	// Write the next free slot on an append with room left.
	assign wr_en = accept && (op == OP_APPEND) && (length_q < DEPTH_L);

	assign cmd.go  = accept && (op == OP_COUNT);
	assign cmd.key = elem;

	// Controller: stay busy from a query transfer until its result strobe.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: begin
				if (cmd.go) begin
					state_d = C_BUSY;
				end
			end
			C_BUSY: begin
				if (res.valid) begin
					state_d = C_IDLE;
				end
			end
			default: begin
				state_d = C_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Length and sticky overflow: advance on append, drop when full, zero on clear.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q   <= '0;
			overflow_q <= 1'b0;
		end else if (accept) begin
			case (op)
				OP_APPEND: begin
					if (length_q < DEPTH_L) begin
						length_q <= length_q + LEN_W'(1);
					end else begin
						overflow_q <= 1'b1;
					end
				end
				OP_CLEAR: begin
					length_q   <= '0;
					overflow_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	sakc_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (length_q[ADDR_W-1:0]),
		.wr_data (elem),
		.rd_en   (srch_rd_en),
		.rd_addr (srch_rd_addr),
		.rd_data (rd_data)
	);

	sakc_search u_search (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.len     (length_q),
		.rd_en   (srch_rd_en),
		.rd_addr (srch_rd_addr),
		.rd_data (rd_data),
		.res     (res)
	);

	assign busy        = (state_q == C_BUSY);
	assign done        = res.valid;
	assign match_count = res.count;
	// Overflow cannot change while a query runs, so it lines up with the strobe.
	assign overflow    = overflow_q;

endmodule
